// ===== rtl/swtfs_pkg.sv =====
package swtfs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_SCAN,
    ST_UP_WRITE,
    ST_OUTER_RD,
    ST_OUTER_LD,
    ST_INNER,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_OLD_RD,
    ST_OLD_LD,
    ST_DN_SCAN,
    ST_DN_WRITE
  } state_t;

  localparam logic IDX_WINDOW_LEN = 1'b0;
  localparam logic IDX_TOP_COUNT  = 1'b1;

  localparam int CFG_W   = 9;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 40;

endpackage

// ===== rtl/swtfs_ram.sv =====
module swtfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sliding_window_top_frequency_sum_top.sv =====
// Sliding-window top-frequency sum.
// Items enter on the in_ channel (in_value, in_start_req) with a valid/ready
// handshake; results leave on the out_ channel as out_x_sum. An item with
// in_start_req set empties the window and the frequency table first.
// Each accepted item is written to the window memory and its count is raised
// by a scan of the frequency table memory. Once the window is full, every
// distinct value is ranked against all others by a second scan, the top
// ranked products are summed, the result is loaded into the output register
// and the oldest value's count is lowered by a third scan.
// The table memory has a single read port, so every scan of the table
// reads its entries one after another.
// The block takes one item at a time; in_ready is high only when it is free.
// A result waits in the output register while out_ready is low; the block
// finishes the current item's work but holds the next result until the
// register is free.
// Reset empties the window and table and sets window_len and top_count to 1.
// No clearing pass is needed: only table entries written since the last
// start are ever read.
module sliding_window_top_frequency_sum_top #(
  parameter int MAX_WINDOW = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [39:0] out_x_sum,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import swtfs_pkg::*;

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int TW   = VALUE_W + CW;
  localparam int PW   = CW + 1 + VALUE_W;
  localparam int SW0  = PW + CW;
  localparam int SW   = (SW0 > SUM_W + 1) ? SW0 : SUM_W + 1;
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam int OW   = CW + 1;

  localparam logic [CW-1:0] MAXC = CW'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST = AW'(MAX_WINDOW - 1);
  localparam logic signed [SW-1:0] SMAX = {{(SW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [CFG_W-1:0] window_len_r, window_len_nxt;
  logic [CFG_W-1:0] top_count_r, top_count_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic out_valid_r, out_valid_nxt;
  logic pend_r, pend_nxt;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [31:0] v_r, v_nxt;
  logic hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [CW-1:0] hit_cnt_r, hit_cnt_nxt;
  logic free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] ci_r, ci_nxt;
  logic [31:0] vi_r, vi_nxt;
  logic [CW-1:0] rank_r, rank_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic take_r, take_nxt;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic signed [39:0] out_x_sum_r, out_x_sum_nxt;

  logic tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [TW-1:0] tab_wdata, tab_rdata;
  logic win_we;
  logic [AW-1:0] win_waddr, win_raddr;
  logic [31:0] win_wdata, win_rdata;

  logic [CW-1:0] rd_cnt;
  logic [31:0] rd_val;
  logic scan_done;
  logic [CMPW-1:0] wl_eff;
  logic [OW-1:0] old_sum;
  logic [AW-1:0] oldest;
  logic signed [SW-1:0] acc_sat;
  logic cfg_wr;
  logic [AW-1:0] wp_eff;
  logic [CW-1:0] fill_eff;

  swtfs_ram #(.WIDTH(TW), .DEPTH(MAX_WINDOW)) u_tab_ram (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  swtfs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_WINDOW)) u_win_ram (
    .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  assign rd_cnt    = tab_rdata[TW-1:VALUE_W];
  assign rd_val    = tab_rdata[VALUE_W-1:0];
  assign scan_done = (idx_r == used_r) && !pend_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_x_sum = out_x_sum_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    if (window_len_r == '0) begin
      wl_eff = CMPW'(1);
    end else if (CMPW'(window_len_r) > CMPW'(MAXC)) begin
      wl_eff = CMPW'(MAXC);
    end else begin
      wl_eff = CMPW'(window_len_r);
    end
  end

  always_comb begin
    old_sum = OW'(wp_r) + OW'(MAXC) - OW'(fill_r);
    if (old_sum >= OW'(MAXC)) begin
      old_sum = old_sum - OW'(MAXC);
    end
    oldest = old_sum[AW-1:0];
  end

  always_comb begin
    if (acc_r > SMAX) begin
      acc_sat = SMAX;
    end else if (acc_r < SMIN) begin
      acc_sat = SMIN;
    end else begin
      acc_sat = acc_r;
    end
  end

  always_comb begin
    case (paddr[2])
      IDX_WINDOW_LEN: prdata = 32'(window_len_r);
      IDX_TOP_COUNT:  prdata = 32'(top_count_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    window_len_nxt = window_len_r;
    top_count_nxt  = top_count_r;
    if (cfg_wr) begin
      case (paddr[2])
        IDX_WINDOW_LEN: window_len_nxt = pwdata[CFG_W-1:0];
        IDX_TOP_COUNT:  top_count_nxt  = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    pend_nxt      = 1'b0;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    v_nxt         = v_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    i_nxt         = i_r;
    ci_nxt        = ci_r;
    vi_nxt        = vi_r;
    rank_nxt      = rank_r;
    prod_nxt      = prod_r;
    take_nxt      = take_r;
    acc_nxt       = acc_r;
    out_x_sum_nxt = out_x_sum_r;
    tab_we        = 1'b0;
    tab_waddr     = hit_idx_r;
    tab_wdata     = {hit_cnt_r, v_r};
    tab_raddr     = idx_r[AW-1:0];
    win_we        = 1'b0;
    win_waddr     = wp_r;
    win_wdata     = in_value;
    win_raddr     = oldest;
    wp_eff        = in_start_req ? '0 : wp_r;
    fill_eff      = in_start_req ? '0 : fill_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == ST_UP_SCAN || state_r == ST_INNER || state_r == ST_DN_SCAN) begin
      if (idx_r != used_r) begin
        idx_nxt  = idx_r + 1'b1;
        pend_nxt = 1'b1;
        pidx_nxt = idx_r[AW-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          win_we    = 1'b1;
          win_waddr = wp_eff;
          wp_nxt    = (wp_eff == LAST) ? '0 : wp_eff + 1'b1;
          fill_nxt  = (fill_eff < MAXC) ? fill_eff + 1'b1 : fill_eff;
          used_nxt  = in_start_req ? '0 : used_r;
          v_nxt     = in_value;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_UP_SCAN;
        end
      end
      ST_UP_SCAN: begin
        if (pend_r) begin
          if (rd_cnt != '0 && rd_val == v_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pidx_r;
            hit_cnt_nxt = rd_cnt;
          end
          if (rd_cnt == '0 && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
        end
        if (scan_done) begin
          state_nxt = ST_UP_WRITE;
        end
      end
      ST_UP_WRITE: begin
        tab_we = 1'b1;
        if (hit_r) begin
          tab_waddr = hit_idx_r;
          tab_wdata = {hit_cnt_r + 1'b1, v_r};
        end else if (free_r) begin
          tab_waddr = free_idx_r;
          tab_wdata = {CW'(1), v_r};
        end else begin
          tab_waddr = used_r[AW-1:0];
          tab_wdata = {CW'(1), v_r};
          used_nxt  = used_r + 1'b1;
        end
        if (CMPW'(fill_r) < wl_eff) begin
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_OUTER_RD;
        end
      end
      ST_OUTER_RD: begin
        tab_raddr = i_r[AW-1:0];
        state_nxt = ST_OUTER_LD;
      end
      ST_OUTER_LD: begin
        ci_nxt    = rd_cnt;
        vi_nxt    = rd_val;
        idx_nxt   = '0;
        rank_nxt  = '0;
        state_nxt = ST_INNER;
      end
      ST_INNER: begin
        if (pend_r && CW'(pidx_r) != i_r && rd_cnt != '0 &&
            (rd_cnt > ci_r || (rd_cnt == ci_r && $signed(rd_val) > $signed(vi_r)))) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (scan_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = $signed({1'b0, ci_r}) * $signed(vi_r);
        take_nxt  = (ci_r != '0) && (CMPW'(rank_r) < CMPW'(top_count_r));
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (take_r) begin
          acc_nxt = acc_r + {{(SW-PW){prod_r[PW-1]}}, prod_r};
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == used_r) ? ST_EMIT : ST_OUTER_RD;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_sum_nxt = acc_sat[SUM_W-1:0];
          state_nxt     = ST_OLD_RD;
        end
      end
      ST_OLD_RD: begin
        win_raddr = oldest;
        state_nxt = ST_OLD_LD;
      end
      ST_OLD_LD: begin
        v_nxt     = win_rdata;
        idx_nxt   = '0;
        hit_nxt   = 1'b0;
        state_nxt = ST_DN_SCAN;
      end
      ST_DN_SCAN: begin
        if (pend_r && !hit_r && rd_cnt != '0 && rd_val == v_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pidx_r;
          hit_cnt_nxt = rd_cnt;
        end
        if (scan_done) begin
          state_nxt = ST_DN_WRITE;
        end
      end
      ST_DN_WRITE: begin
        if (hit_r) begin
          tab_we    = 1'b1;
          tab_waddr = hit_idx_r;
          tab_wdata = {hit_cnt_r - 1'b1, v_r};
        end
        fill_nxt  = fill_r - 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_len_r <= CFG_W'(1);
      top_count_r  <= CFG_W'(1);
      fill_r       <= '0;
      wp_r         <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      window_len_r <= window_len_nxt;
      top_count_r  <= top_count_nxt;
      fill_r       <= fill_nxt;
      wp_r         <= wp_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    v_r         <= v_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    i_r         <= i_nxt;
    ci_r        <= ci_nxt;
    vi_r        <= vi_nxt;
    rank_r      <= rank_nxt;
    prod_r      <= prod_nxt;
    take_r      <= take_nxt;
    acc_r       <= acc_nxt;
    out_x_sum_r <= out_x_sum_nxt;
  end

endmodule
